### rtl/core/srl_pkg.sv
`default_nettype none
package srl_pkg;
  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int KeyW = 32;
  localparam int PayW = 32;
  localparam int RecW = KeyW + PayW;
  localparam int KindW = 3;
  localparam int PosW = 7;

  typedef enum logic [KindW-1:0] {
    OP_INS_END   = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_SORT  = 3'd2,
    OP_RM_END    = 3'd3,
    OP_RM_FRONT  = 3'd4,
    OP_RM_KEY    = 3'd5,
    OP_READ_POS  = 3'd6,
    OP_FIND_KEY  = 3'd7
  } op_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic signed [KeyW-1:0] entry_key;
    logic [PayW-1:0] entry_payload;
    logic [PosW-1:0] position;
  } req_t;

  typedef struct packed {
    logic ok;
    logic signed [KeyW-1:0] found_key;
    logic [PayW-1:0] found_payload;
    logic [PosW-1:0] entry_count;
    logic is_full;
    logic is_empty;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request, clear index, target and found record
    logic rd_cur;      // read memory at idx
    logic rd_below;    // read memory at idx - 1
    logic rd_above;    // read memory at idx + 1
    logic step_up;     // idx + 1
    logic step_down;   // idx - 1
    logic set_top;     // idx = count
    logic set_pos;     // idx = position - 1
    logic set_tgt;     // target = idx
    logic wr_move;     // mem[idx] = rdata
    logic wr_new;      // mem[idx] = new record
    logic cnt_inc;
    logic cnt_dec;
    logic cap_found;   // latch rdata as found record
    logic rsp_ok;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic key_match;     // rdata key == request key
    logic key_ge;        // rdata key >= request key
    logic pos_ok;        // 1 <= position <= count
    logic idx_last;      // idx + 1 == count
    logic up_last;       // idx - 1 == target
    logic dn_last;       // idx + 2 == count
  } sts_t;
endpackage
`default_nettype wire

### rtl/core/srl_if.sv
`default_nettype none
interface srl_req_if;
  logic valid;
  logic ready;
  srl_pkg::req_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface srl_rsp_if;
  logic valid;
  logic ready;
  srl_pkg::rsp_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/core/srl_datapath.sv
`default_nettype none
module srl_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire srl_pkg::req_t   req,
  input  wire srl_pkg::cmd_t   cmd,
  output srl_pkg::sts_t        sts,
  output srl_pkg::rsp_t        rsp
);
  logic [srl_pkg::RecW-1:0]        mem [srl_pkg::Capacity];
  logic [srl_pkg::RecW-1:0]        rdata;
  logic [srl_pkg::RecW-1:0]        wr_data;
  srl_pkg::req_t                   cur;
  logic [srl_pkg::CntW-1:0]        idx;
  logic [srl_pkg::CntW-1:0]        idx_dn;
  logic [srl_pkg::CntW-1:0]        idx_up;
  logic [srl_pkg::CntW-1:0]        tgt;
  logic [srl_pkg::CntW-1:0]        count;
  logic [srl_pkg::IdxW-1:0]        rd_addr;
  logic signed [srl_pkg::KeyW-1:0] fkey;
  logic [srl_pkg::PayW-1:0]        fpay;
  logic signed [srl_pkg::KeyW-1:0] rkey;

  assign idx_dn = idx - 1'b1;
  assign idx_up = idx + 1'b1;
  assign rkey = rdata[srl_pkg::RecW-1:srl_pkg::PayW];
  assign wr_data = cmd.wr_new ? {cur.entry_key, cur.entry_payload} : rdata;

  always_comb begin
    if (cmd.rd_below) begin
      rd_addr = idx_dn[srl_pkg::IdxW-1:0];
    end else if (cmd.rd_above) begin
      rd_addr = idx_up[srl_pkg::IdxW-1:0];
    end else begin
      rd_addr = idx[srl_pkg::IdxW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_move || cmd.wr_new) begin
      mem[idx[srl_pkg::IdxW-1:0]] <= wr_data;
    end
    if (cmd.rd_cur || cmd.rd_below || cmd.rd_above) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
      fkey <= '0;
      fpay <= '0;
    end else if (cmd.cap_found) begin
      fkey <= rkey;
      fpay <= rdata[srl_pkg::PayW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      tgt <= '0;
      count <= '0;
    end else begin
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.set_top) begin
        idx <= count;
      end else if (cmd.set_pos) begin
        idx <= srl_pkg::CntW'(cur.position - 1'b1);
      end else if (cmd.step_up) begin
        idx <= idx_up;
      end else if (cmd.step_down) begin
        idx <= idx_dn;
      end
      if (cmd.load) begin
        tgt <= '0;
      end else if (cmd.set_tgt) begin
        tgt <= idx;
      end
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
    end
  end

  always_comb begin
    sts.full = count == srl_pkg::CntW'(srl_pkg::Capacity);
    sts.empty = count == '0;
    sts.key_match = rkey == cur.entry_key;
    sts.key_ge = rkey >= cur.entry_key;
    sts.pos_ok = cur.position != '0 && cur.position <= count;
    sts.idx_last = idx_up == count;
    sts.up_last = idx_dn == tgt;
    sts.dn_last = (idx_up + 1'b1) == count;
  end

  always_comb begin
    rsp.ok = cmd.rsp_ok;
    rsp.found_key = fkey;
    rsp.found_payload = fpay;
    rsp.entry_count = srl_pkg::PosW'(count);
    rsp.is_full = sts.full;
    rsp.is_empty = sts.empty;
  end
endmodule
`default_nettype wire

### rtl/core/srl_ctrl.sv
`default_nettype none
module srl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [srl_pkg::KindW-1:0] in_kind,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire srl_pkg::sts_t  sts,
  output srl_pkg::cmd_t       cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK, S_POS_RD, S_POS_CAP,
    S_UP_RD, S_UP_WR, S_INS, S_DN_RD, S_DN_WR, S_DONE
  } state_t;

  state_t       state;
  state_t       state_next;
  srl_pkg::op_t op;
  logic         ok;
  logic         ok_next;
  logic         hit;

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_DONE;
  // sorted insert stops at the first key not less than the new one
  assign hit = (op == srl_pkg::OP_INS_SORT) ? sts.key_ge : sts.key_match;

  always_comb begin
    cmd = '0;
    cmd.rsp_ok = ok;
    state_next = state;
    ok_next = ok;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          ok_next = 1'b0;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op)
          srl_pkg::OP_INS_END: begin
            if (sts.full) begin
              state_next = S_DONE;
            end else begin
              cmd.set_top = 1'b1;
              state_next = S_INS;
            end
          end
          srl_pkg::OP_INS_FRONT: begin
            if (sts.full) begin
              state_next = S_DONE;
            end else begin
              cmd.set_top = 1'b1;
              state_next = sts.empty ? S_INS : S_UP_RD;
            end
          end
          srl_pkg::OP_INS_SORT: begin
            if (sts.full) begin
              state_next = S_DONE;
            end else begin
              state_next = sts.empty ? S_INS : S_SCAN_RD;
            end
          end
          srl_pkg::OP_RM_END: begin
            if (!sts.empty) begin
              cmd.cnt_dec = 1'b1;
              ok_next = 1'b1;
            end
            state_next = S_DONE;
          end
          srl_pkg::OP_RM_FRONT: begin
            if (sts.empty) begin
              state_next = S_DONE;
            end else begin
              ok_next = 1'b1;
              if (sts.idx_last) begin
                cmd.cnt_dec = 1'b1;
                state_next = S_DONE;
              end else begin
                state_next = S_DN_RD;
              end
            end
          end
          srl_pkg::OP_RM_KEY, srl_pkg::OP_FIND_KEY: begin
            state_next = sts.empty ? S_DONE : S_SCAN_RD;
          end
          srl_pkg::OP_READ_POS: begin
            if (sts.pos_ok) begin
              cmd.set_pos = 1'b1;
              state_next = S_POS_RD;
            end else begin
              state_next = S_DONE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (hit) begin
          if (op == srl_pkg::OP_FIND_KEY) begin
            cmd.cap_found = 1'b1;
            ok_next = 1'b1;
            state_next = S_DONE;
          end else if (op == srl_pkg::OP_RM_KEY) begin
            ok_next = 1'b1;
            if (sts.idx_last) begin
              cmd.cnt_dec = 1'b1;
              state_next = S_DONE;
            end else begin
              state_next = S_DN_RD;
            end
          end else begin
            cmd.set_tgt = 1'b1;
            cmd.set_top = 1'b1;
            state_next = S_UP_RD;
          end
        end else if (sts.idx_last) begin
          // no hit: sorted insert appends, the others fail
          if (op == srl_pkg::OP_INS_SORT) begin
            cmd.step_up = 1'b1;
            state_next = S_INS;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          cmd.step_up = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_POS_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_POS_CAP;
      end
      S_POS_CAP: begin
        cmd.cap_found = 1'b1;
        ok_next = 1'b1;
        state_next = S_DONE;
      end
      // open a gap: move records up from the top down to the target
      S_UP_RD: begin
        cmd.rd_below = 1'b1;
        state_next = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.wr_move = 1'b1;
        cmd.step_down = 1'b1;
        state_next = sts.up_last ? S_INS : S_UP_RD;
      end
      S_INS: begin
        cmd.wr_new = 1'b1;
        cmd.cnt_inc = 1'b1;
        ok_next = 1'b1;
        state_next = S_DONE;
      end
      // close the gap at idx: move the records above it down
      S_DN_RD: begin
        cmd.rd_above = 1'b1;
        state_next = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.wr_move = 1'b1;
        cmd.step_up = 1'b1;
        if (sts.dn_last) begin
          cmd.cnt_dec = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_DN_RD;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= srl_pkg::OP_INS_END;
      ok <= 1'b0;
    end else begin
      state <= state_next;
      ok <= ok_next;
      if (cmd.load) begin
        op <= srl_pkg::op_t'(in_kind);
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/sorted_record_list.sv
`default_nettype none
// channel  | dir | payload
// req      | in  | kind, entry_key, entry_payload, position
// rsp      | out | ok, found_key, found_payload, entry_count, is_full, is_empty
// one operation at a time; scan steps read then check, moves read then write
// the longest operation is a sorted insert at the front of a 63-record list
// (dispatch, one scan step, 63 moves, write); the next request beat can come
// the cycle after the result
// reset clears the record count; records are undefined until written
// req.ready is low while an operation runs or its result waits
module sorted_record_list (
  input wire logic clk,
  input wire logic rst,
  srl_req_if.sink   req,
  srl_rsp_if.source rsp
);
  srl_pkg::cmd_t cmd;
  srl_pkg::sts_t sts;

  // sequencing of scans, shifts and the result beat
  srl_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .in_kind(req.payload.kind),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .sts(sts),
    .cmd(cmd)
  );

  // record memory, index, count and the found record
  srl_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .req(req.payload),
    .cmd(cmd),
    .sts(sts),
    .rsp(rsp.payload)
  );

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> $stable(rsp.payload)) else $error("result changed");
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.payload.entry_count <= srl_pkg::PosW'(srl_pkg::Capacity))
    else $error("count above capacity");
endmodule
`default_nettype wire
